// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. The enclosing module must have clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// File: rtl/qchm_pkg.sv
`default_nettype none

package qchm_pkg;

  localparam int CHAN_BITS       = 8;
  localparam int LEVEL_BITS      = 4;
  localparam int BIN_BITS        = 10;
  localparam int NUM_BINS        = 1000;
  localparam int MODE_COUNT_BITS = 32;
  localparam int NUM_STEPS       = 9;

  localparam logic [BIN_BITS-1:0]   BIN_LAST     = BIN_BITS'(NUM_BINS - 1);
  localparam logic [LEVEL_BITS-1:0] EXCL_LEVEL   = LEVEL_BITS'(1);
  localparam logic [CHAN_BITS-1:0]  CHAN_FULL    = '1;

  // Smallest channel value of levels 1 through 9, i.e. ceil(k * 255 / 10).
  localparam logic [CHAN_BITS-1:0] LEVEL_STEP [NUM_STEPS] = '{
    8'd26, 8'd51, 8'd77, 8'd102, 8'd128, 8'd153, 8'd179, 8'd204, 8'd230
  };

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // floor(v * 10 / 255) mod 10: full scale wraps back to level zero.
  function automatic logic [LEVEL_BITS-1:0] quantize(input logic [CHAN_BITS-1:0] v);
    logic [LEVEL_BITS-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (v >= LEVEL_STEP[i]) begin
        lvl = lvl + LEVEL_BITS'(1);
      end
    end
    if (v == CHAN_FULL) begin
      lvl = '0;
    end
    return lvl;
  endfunction

  function automatic logic [BIN_BITS-1:0] bin_index(input logic [LEVEL_BITS-1:0] r,
                                                    input logic [LEVEL_BITS-1:0] g,
                                                    input logic [LEVEL_BITS-1:0] b);
    return BIN_BITS'(r) * BIN_BITS'(100) + BIN_BITS'(g) * BIN_BITS'(10) + BIN_BITS'(b);
  endfunction

endpackage

`default_nettype wire

// File: rtl/qchm_pixel_if.sv
`default_nettype none

interface qchm_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [qchm_pkg::CHAN_BITS-1:0] red;
  logic [qchm_pkg::CHAN_BITS-1:0] green;
  logic [qchm_pkg::CHAN_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// File: rtl/qchm_result_if.sv
`default_nettype none

interface qchm_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 counted;
  logic [qchm_pkg::LEVEL_BITS-1:0]      mode_red_level;
  logic [qchm_pkg::LEVEL_BITS-1:0]      mode_green_level;
  logic [qchm_pkg::LEVEL_BITS-1:0]      mode_blue_level;
  logic [qchm_pkg::MODE_COUNT_BITS-1:0] mode_count;

  modport source (output valid, output counted, output mode_red_level,
                  output mode_green_level, output mode_blue_level,
                  output mode_count, input ready);
  modport sink   (input valid, input counted, input mode_red_level,
                  input mode_green_level, input mode_blue_level,
                  input mode_count, output ready);
endinterface

`default_nettype wire

// File: rtl/qchm_bin_ram.sv
`default_nettype none

module qchm_bin_ram #(
  parameter int DATA_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [qchm_pkg::BIN_BITS-1:0] waddr,
  input  wire logic [DATA_BITS-1:0]          wdata,
  input  wire logic                          re,
  input  wire logic [qchm_pkg::BIN_BITS-1:0] raddr,
  output logic      [DATA_BITS-1:0]          rdata
);

  logic [DATA_BITS-1:0] mem [qchm_pkg::NUM_BINS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-before-write: a read of the address written at the same edge returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/quantized_color_histogram_mode_core.sv
`default_nettype none
`include "assert_macros.svh"

// Color histogram with running mode over quantized RGB pixels.
// The pix channel takes one pixel (red, green, blue) per item; the res channel
// returns one result item per pixel: whether it was counted, plus the levels
// and count of the current mode bin after that pixel.
// Each channel is quantized to ten levels; the three levels address one of
// 1000 saturating counters held in a single-port-write, one-read RAM.
// The RAM is read at the accept edge; the counter update, mode update and result
// register load happen at the edge on which the item leaves the update stage.
// Throughput, while res.ready is high, is one item per cycle, including runs
// of pixels that hit the same bin, since the value being written is forwarded
// into the read stage. After reset the block sweeps the RAM, writing zero to
// one counter per cycle, and holds pix.ready low until the sweep is done.
// The result sits in an output register; when res.ready is low, one more item
// may be accepted and waits in the update stage, after which pix.ready drops
// until the result is taken.

module quantized_color_histogram_mode_core #(
  parameter int COUNT_BITS = 32
) (
  input wire logic     clk,
  input wire logic     rst,
  qchm_pixel_if.sink   pix,
  qchm_result_if.source res
);

  qchm_pkg::state_t state;
  qchm_pkg::state_t state_next;
  logic [qchm_pkg::BIN_BITS-1:0] clr_addr;

  logic [qchm_pkg::LEVEL_BITS-1:0] in_red;
  logic [qchm_pkg::LEVEL_BITS-1:0] in_green;
  logic [qchm_pkg::LEVEL_BITS-1:0] in_blue;
  logic [qchm_pkg::BIN_BITS-1:0]   in_bin;
  logic                            in_counted;
  logic                            accept;
  logic                            advance;

  logic                            s1_valid;
  logic                            s1_counted;
  logic [qchm_pkg::BIN_BITS-1:0]   s1_bin;
  logic [qchm_pkg::LEVEL_BITS-1:0] s1_red;
  logic [qchm_pkg::LEVEL_BITS-1:0] s1_green;
  logic [qchm_pkg::LEVEL_BITS-1:0] s1_blue;

  logic                            fwd_hit;
  logic [COUNT_BITS-1:0]           fwd_data;
  logic [COUNT_BITS-1:0]           ram_rdata;
  logic                            ram_we;
  logic [qchm_pkg::BIN_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0]           ram_wdata;

  logic [COUNT_BITS-1:0]           cur;
  logic [COUNT_BITS-1:0]           inc;
  logic                            bump;
  logic                            take;

  logic [COUNT_BITS-1:0]           best_count;
  logic [COUNT_BITS-1:0]           best_count_next;
  logic [qchm_pkg::BIN_BITS-1:0]   best_bin;
  logic [qchm_pkg::BIN_BITS-1:0]   best_bin_next;
  logic [qchm_pkg::LEVEL_BITS-1:0] best_red;
  logic [qchm_pkg::LEVEL_BITS-1:0] best_red_next;
  logic [qchm_pkg::LEVEL_BITS-1:0] best_green;
  logic [qchm_pkg::LEVEL_BITS-1:0] best_green_next;
  logic [qchm_pkg::LEVEL_BITS-1:0] best_blue;
  logic [qchm_pkg::LEVEL_BITS-1:0] best_blue_next;
  logic [63:0]                     best_wide;

  logic                                 out_valid;
  logic                                 out_counted;
  logic [qchm_pkg::LEVEL_BITS-1:0]      out_red;
  logic [qchm_pkg::LEVEL_BITS-1:0]      out_green;
  logic [qchm_pkg::LEVEL_BITS-1:0]      out_blue;
  logic [qchm_pkg::MODE_COUNT_BITS-1:0] out_count;

  // Input side: quantize and form the bin address.
  assign in_red     = qchm_pkg::quantize(pix.red);
  assign in_green   = qchm_pkg::quantize(pix.green);
  assign in_blue    = qchm_pkg::quantize(pix.blue);
  assign in_bin     = qchm_pkg::bin_index(in_red, in_green, in_blue);
  assign in_counted = !(in_red == qchm_pkg::EXCL_LEVEL && in_green == qchm_pkg::EXCL_LEVEL &&
                        in_blue == qchm_pkg::EXCL_LEVEL);

  assign advance   = s1_valid && (!out_valid || res.ready);
  assign pix.ready = (state == qchm_pkg::ST_RUN) && (!s1_valid || advance);
  assign accept    = pix.valid && pix.ready;

  // Clear sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= qchm_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == qchm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + qchm_pkg::BIN_BITS'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      qchm_pkg::ST_CLEAR: begin
        if (clr_addr == qchm_pkg::BIN_LAST) begin
          state_next = qchm_pkg::ST_RUN;
        end
      end
      qchm_pkg::ST_RUN: begin
        state_next = qchm_pkg::ST_RUN;
      end
      default: begin
        state_next = qchm_pkg::ST_CLEAR;
      end
    endcase
  end

  // Update stage: read data arrives, counter and mode are updated.
  assign cur  = fwd_hit ? fwd_data : ram_rdata;
  assign inc  = cur + COUNT_BITS'(1);
  assign bump = advance && s1_counted && (cur != '1);
  assign take = bump && (s1_bin != '0) &&
                ((inc > best_count) || ((inc == best_count) && (s1_bin < best_bin)));

  assign best_count_next = take ? inc      : best_count;
  assign best_bin_next   = take ? s1_bin   : best_bin;
  assign best_red_next   = take ? s1_red   : best_red;
  assign best_green_next = take ? s1_green : best_green;
  assign best_blue_next  = take ? s1_blue  : best_blue;
  assign best_wide       = 64'(best_count_next);

  always_comb begin
    if (state == qchm_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = bump;
      ram_waddr = s1_bin;
      ram_wdata = inc;
    end
  end

  qchm_bin_ram #(
    .DATA_BITS (COUNT_BITS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_bin),
    .rdata (ram_rdata)
  );

  // The RAM returns old data for a bin written at the same edge, so that value is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= bump && (s1_bin == in_bin);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_counted <= in_counted;
      s1_bin     <= in_bin;
      s1_red     <= in_red;
      s1_green   <= in_green;
      s1_blue    <= in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_count <= '0;
      best_bin   <= '0;
      best_red   <= '0;
      best_green <= '0;
      best_blue  <= '0;
    end else begin
      best_count <= best_count_next;
      best_bin   <= best_bin_next;
      best_red   <= best_red_next;
      best_green <= best_green_next;
      best_blue  <= best_blue_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_counted <= s1_counted;
      out_red     <= best_red_next;
      out_green   <= best_green_next;
      out_blue    <= best_blue_next;
      out_count   <= best_wide[qchm_pkg::MODE_COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid            = out_valid;
  assign res.counted          = out_counted;
  assign res.mode_red_level   = out_red;
  assign res.mode_green_level = out_green;
  assign res.mode_blue_level  = out_blue;
  assign res.mode_count       = out_count;

  `ASSERT_NEXT(a_best_count_monotonic, !rst, best_count >= $past(best_count))
  `ASSERT_IMPL(a_mode_never_bin_zero, best_count != '0, best_bin != '0)
  `ASSERT_NEXT(a_stall_freezes_mode, !rst && res.valid && !res.ready,
               $stable(best_count) && $stable(best_bin))

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int          COUNT_W      = 32;
  localparam int unsigned LEVELS       = 10;
  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned EXCLUDED_BIN = 111;
  localparam int          RANDOM_ITEMS = 632;
  localparam int          HOLD_OFF     = 200;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          ROWS         = 18;

  typedef struct packed {
    logic [qchm_pkg::CHAN_BITS-1:0] red;
    logic [qchm_pkg::CHAN_BITS-1:0] green;
    logic [qchm_pkg::CHAN_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                                 counted;
    logic [qchm_pkg::LEVEL_BITS-1:0]      red_lvl;
    logic [qchm_pkg::LEVEL_BITS-1:0]      green_lvl;
    logic [qchm_pkg::LEVEL_BITS-1:0]      blue_lvl;
    logic [qchm_pkg::MODE_COUNT_BITS-1:0] count;
  } mode_result_t;

  typedef struct packed {
    pixel_t       px;
    logic         typed;
    mode_result_t want;
  } directed_row_t;

  // Rows with typed set carry a hand-computed result; the others use the predictor.
  localparam directed_row_t DIRECTED [ROWS] = '{
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{1'b1, 4'd0, 4'd0, 4'd0, 32'd0}},
    '{'{8'd0,   8'd0,   8'd0},   1'b1, '{1'b1, 4'd0, 4'd0, 4'd0, 32'd0}},
    '{'{8'd25,  8'd0,   8'd255}, 1'b1, '{1'b1, 4'd0, 4'd0, 4'd0, 32'd0}},
    '{'{8'd26,  8'd26,  8'd26},  1'b1, '{1'b0, 4'd0, 4'd0, 4'd0, 32'd0}},
    '{'{8'd50,  8'd50,  8'd50},  1'b1, '{1'b0, 4'd0, 4'd0, 4'd0, 32'd0}},
    '{'{8'd30,  8'd45,  8'd38},  1'b1, '{1'b0, 4'd0, 4'd0, 4'd0, 32'd0}},
    '{'{8'd254, 8'd254, 8'd254}, 1'b1, '{1'b1, 4'd9, 4'd9, 4'd9, 32'd1}},
    '{'{8'd0,   8'd0,   8'd26},  1'b1, '{1'b1, 4'd0, 4'd0, 4'd1, 32'd1}},
    '{'{8'd230, 8'd229, 8'd128}, 1'b0, '0},
    '{'{8'd51,  8'd26,  8'd26},  1'b0, '0},
    '{'{8'd26,  8'd51,  8'd26},  1'b0, '0},
    '{'{8'd26,  8'd26,  8'd51},  1'b0, '0},
    '{'{8'd127, 8'd76,  8'd101}, 1'b0, '0},
    '{'{8'd240, 8'd240, 8'd240}, 1'b1, '{1'b1, 4'd9, 4'd9, 4'd9, 32'd2}},
    '{'{8'd0,   8'd0,   8'd26},  1'b1, '{1'b1, 4'd0, 4'd0, 4'd1, 32'd2}},
    '{'{8'd170, 8'd85,  8'd204}, 1'b0, '0},
    '{'{8'd128, 8'd128, 8'd128}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd0},   1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  qchm_pixel_if  pixel_ch ();
  qchm_result_if result_ch ();

  quantized_color_histogram_mode_core #(
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .pix(pixel_ch),
    .res(result_ch)
  );

  always #5 clk = ~clk;

  logic [COUNT_W-1:0] hist_counts [qchm_pkg::NUM_BINS];
  logic [COUNT_W-1:0] lead_count;
  int unsigned        lead_bin;
  mode_result_t       expected_modes [$];
  int unsigned        hot_a;
  int unsigned        hot_b;
  int                 pixels_in = 0;
  int                 send_run_left = 0;
  int                 errors = 0;
  int                 cycle_count = 0;

  function automatic logic [qchm_pkg::LEVEL_BITS-1:0] level_of(
      input logic [qchm_pkg::CHAN_BITS-1:0] v);
    return qchm_pkg::LEVEL_BITS'(((32'(v) * LEVELS) / FULL_SCALE) % LEVELS);
  endfunction

  // Updates the histogram and the running mode, and returns the result item.
  function automatic mode_result_t tally_pixel(input pixel_t px);
    logic [qchm_pkg::LEVEL_BITS-1:0] r_l;
    logic [qchm_pkg::LEVEL_BITS-1:0] g_l;
    logic [qchm_pkg::LEVEL_BITS-1:0] b_l;
    int unsigned                     slot;
    mode_result_t                    outcome;
    r_l = level_of(px.red);
    g_l = level_of(px.green);
    b_l = level_of(px.blue);
    slot = r_l * 100 + g_l * 10 + b_l;
    outcome.counted = 1'b0;
    if (!(r_l == qchm_pkg::EXCL_LEVEL && g_l == qchm_pkg::EXCL_LEVEL &&
          b_l == qchm_pkg::EXCL_LEVEL)) begin
      outcome.counted = 1'b1;
      if (hist_counts[slot] != '1) begin
        hist_counts[slot] = hist_counts[slot] + 1'b1;
        // Bin zero is counted but may never become the mode.
        if (slot != 0 && (hist_counts[slot] > lead_count ||
            (hist_counts[slot] == lead_count && slot < lead_bin))) begin
          lead_count = hist_counts[slot];
          lead_bin = slot;
        end
      end
    end
    outcome.red_lvl = qchm_pkg::LEVEL_BITS'(lead_bin / 100);
    outcome.green_lvl = qchm_pkg::LEVEL_BITS'((lead_bin / 10) % 10);
    outcome.blue_lvl = qchm_pkg::LEVEL_BITS'(lead_bin % 10);
    outcome.count = qchm_pkg::MODE_COUNT_BITS'(lead_count);
    return outcome;
  endfunction

  function automatic logic [qchm_pkg::CHAN_BITS-1:0] channel_for_level(input int unsigned lvl);
    logic [qchm_pkg::CHAN_BITS-1:0] v;
    do begin
      v = qchm_pkg::CHAN_BITS'($urandom_range(0, 255));
    end while (level_of(v) != lvl);
    return v;
  endfunction

  // Mostly pixels for two racing hot bins, so that ties occur,
  // with some fully random, excluded and bin-zero pixels mixed in.
  function automatic pixel_t random_pixel();
    int unsigned roll;
    int unsigned slot;
    pixel_t      px;
    roll = $urandom_range(0, 99);
    if (roll >= 88 && roll < 95) begin
      px.red = qchm_pkg::CHAN_BITS'($urandom_range(0, 255));
      px.green = qchm_pkg::CHAN_BITS'($urandom_range(0, 255));
      px.blue = qchm_pkg::CHAN_BITS'($urandom_range(0, 255));
    end else begin
      slot = (roll < 44) ? hot_a : (roll < 88) ? hot_b : (roll < 98) ? EXCLUDED_BIN : 0;
      px.red = channel_for_level(slot / 100);
      px.green = channel_for_level((slot / 10) % 10);
      px.blue = channel_for_level(slot % 10);
    end
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px, input logic typed, input mode_result_t want);
    mode_result_t predicted;
    int unsigned  roll;
    int unsigned  gap;
    pixel_ch.valid <= 1'b1;
    pixel_ch.red <= px.red;
    pixel_ch.green <= px.green;
    pixel_ch.blue <= px.blue;
    do @(posedge clk); while (!pixel_ch.ready);
    predicted = tally_pixel(px);
    expected_modes.push_back(typed ? want : predicted);
    pixels_in++;
    gap = 0;
    if (send_run_left > 0) begin
      send_run_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_run_left = $urandom_range(10, 40);
      end else if (roll < 40) begin
        gap = $urandom_range(1, 3);
      end else if (roll < 45) begin
        gap = $urandom_range(8, 30);
      end
    end
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input longint unsigned want_v,
                               input longint unsigned got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : check_results
    mode_result_t got;
    mode_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.counted = result_ch.counted;
      got.red_lvl = result_ch.mode_red_level;
      got.green_lvl = result_ch.mode_green_level;
      got.blue_lvl = result_ch.mode_blue_level;
      got.count = result_ch.mode_count;
      if (expected_modes.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, expected none, actual %h",
                 $time, got);
      end else begin
        want = expected_modes.pop_front();
        if (got.counted !== want.counted) note_mismatch("counted", want.counted, got.counted);
        if (got.red_lvl !== want.red_lvl)
          note_mismatch("mode_red_level", want.red_lvl, got.red_lvl);
        if (got.green_lvl !== want.green_lvl)
          note_mismatch("mode_green_level", want.green_lvl, got.green_lvl);
        if (got.blue_lvl !== want.blue_lvl)
          note_mismatch("mode_blue_level", want.blue_lvl, got.blue_lvl);
        if (got.count !== want.count) note_mismatch("mode_count", want.count, got.count);
      end
    end
  end

  // Result side: random stalls, stretches always ready, and one long hold-off
  // early on so that the block fills up and drops pix.ready.
  initial begin : result_sink
    int  stall_left;
    int  run_left;
    int  roll;
    bit  held_off;
    stall_left = 0;
    run_left = 0;
    held_off = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && pixels_in >= 60) begin
        held_off = 1'b1;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        result_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          run_left = $urandom_range(20, 60);
          result_ch.ready <= 1'b1;
        end else if (roll < 25) begin
          stall_left = $urandom_range(0, 2);
          result_ch.ready <= 1'b0;
        end else if (roll < 28) begin
          stall_left = $urandom_range(9, 39);
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : pixel_source
    rst <= 1'b1;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red <= '0;
    pixel_ch.green <= '0;
    pixel_ch.blue <= '0;
    foreach (hist_counts[i]) hist_counts[i] = '0;
    lead_count = '0;
    lead_bin = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ROWS; i++) begin
      send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
    end

    do begin
      hot_a = $urandom_range(1, qchm_pkg::NUM_BINS - 1);
    end while (hot_a == EXCLUDED_BIN);
    do begin
      hot_b = $urandom_range(1, qchm_pkg::NUM_BINS - 1);
    end while (hot_b == EXCLUDED_BIN || hot_b == hot_a);

    repeat (RANDOM_ITEMS) send_pixel(random_pixel(), 1'b0, '0);
    pixel_ch.valid <= 1'b0;

    while (expected_modes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
